// ===== src/eors_pkg.sv =====
// ----------------------------------------------------------------------------
// eors_pkg
// shared types and constants for the even-only row sort block
// ----------------------------------------------------------------------------
package eors_pkg;

   localparam int ROW_LEN = 64;
   localparam int IDX_W   = $clog2(ROW_LEN);
   localparam int CNT_W   = $clog2(ROW_LEN + 1);
   localparam int DATA_W  = 16;

   typedef struct packed {
      logic signed [DATA_W-1:0] element_value;
      logic                     row_end;
   } req_type;

   typedef struct packed {
      logic signed [DATA_W-1:0] sorted_value;
      logic                     row_done;
   } rsp_type;

   typedef enum logic [1:0] {
      RD_I  = 2'd0,
      RD_I1 = 2'd1,
      RD_J1 = 2'd2,
      RD_K  = 2'd3
   } rd_sel_type;

   typedef struct packed {
      logic       load;
      logic       rd_en;
      rd_sel_type rd_sel;
      logic       cap_x;
      logic       set_j;
      logic       cmp;
      logic       wr_i;
      logic       inc_i;
      logic       out_load;
   } dp_cmd_type;

   typedef struct packed {
      logic next_len_one;
      logic j_last;
      logic i_last;
      logic k_last;
      logic out_free;
   } dp_status_type;

endpackage

// ===== src/eors_ram.sv =====
// ----------------------------------------------------------------------------
// eors_ram
// generic single write, single read ram with registered read data
// ----------------------------------------------------------------------------
module eors_ram #(
   parameter int WIDTH = 16,
   parameter int DEPTH = 64
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic                     rd_en,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= mem_ff[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

// ===== src/eors_ctrl.sv =====
// ----------------------------------------------------------------------------
// eors_ctrl
// sequencer for load, exchange sort and emission of one row
// ----------------------------------------------------------------------------
module eors_ctrl (
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   req_valid,
   input  logic                   req_row_end,
   output logic                   req_stall,
   input  eors_pkg::dp_status_type status,
   output eors_pkg::dp_cmd_type    cmd
);
   import eors_pkg::*;

   typedef enum logic [6:0] {
      S_LOAD   = 7'b0000001,
      S_RD_I   = 7'b0000010,
      S_GET_I  = 7'b0000100,
      S_CMP    = 7'b0001000,
      S_WR_I   = 7'b0010000,
      S_EM_RD  = 7'b0100000,
      S_EM_CAP = 7'b1000000
   } state_type;

   state_type state_ff, state_in;

   always_comb begin
      state_in = state_ff;
      cmd      = '0;
      cmd.rd_sel = RD_I;
      case (state_ff)
         S_LOAD: begin
            if (req_valid) begin
               cmd.load = 1'b1;
               if (req_row_end) begin
                  state_in = status.next_len_one ? S_EM_RD : S_RD_I;
               end
            end
         end
         S_RD_I: begin
            cmd.rd_en  = 1'b1;
            cmd.rd_sel = RD_I;
            state_in   = S_GET_I;
         end
         S_GET_I: begin
            cmd.cap_x  = 1'b1;
            cmd.set_j  = 1'b1;
            cmd.rd_en  = 1'b1;
            cmd.rd_sel = RD_I1;
            state_in   = S_CMP;
         end
         S_CMP: begin
            cmd.cmp = 1'b1;
            if (status.j_last) begin
               state_in = S_WR_I;
            end else begin
               cmd.rd_en  = 1'b1;
               cmd.rd_sel = RD_J1;
            end
         end
         S_WR_I: begin
            cmd.wr_i = 1'b1;
            if (status.i_last) begin
               state_in = S_EM_RD;
            end else begin
               cmd.inc_i = 1'b1;
               state_in  = S_RD_I;
            end
         end
         S_EM_RD: begin
            if (status.out_free) begin
               cmd.rd_en  = 1'b1;
               cmd.rd_sel = RD_K;
               state_in   = S_EM_CAP;
            end
         end
         S_EM_CAP: begin
            cmd.out_load = 1'b1;
            state_in     = status.k_last ? S_LOAD : S_EM_RD;
         end
         default: begin
            state_in = S_LOAD;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_LOAD;
      end else begin
         state_ff <= state_in;
      end
   end

   assign req_stall = (state_ff != S_LOAD);

endmodule

// ===== src/eors_dpath.sv =====
// ----------------------------------------------------------------------------
// eors_dpath
// row store, index counters, compare and swap, output register
// ----------------------------------------------------------------------------
module eors_dpath (
   input  logic                    clock,
   input  logic                    reset,
   input  eors_pkg::req_type       req_data,
   input  logic                    rsp_stall,
   output logic                    rsp_valid,
   output eors_pkg::rsp_type       rsp_data,
   input  eors_pkg::dp_cmd_type    cmd,
   output eors_pkg::dp_status_type status
);
   import eors_pkg::*;

   logic [CNT_W-1:0]  fill_ff, len_ff, len_next;
   logic [IDX_W-1:0]  i_ff, j_ff, k_ff;
   logic [DATA_W-1:0] x_ff;
   logic              out_valid_ff;
   rsp_type           out_ff;

   logic              fill_full, swap, close;
   logic              wr_en;
   logic [IDX_W-1:0]  wr_addr, rd_addr;
   logic [DATA_W-1:0] wr_data, rd_data;

   assign fill_full = (fill_ff == CNT_W'(ROW_LEN));
   assign len_next  = fill_full ? fill_ff : fill_ff + CNT_W'(1);
   assign close     = cmd.load & req_data.row_end;
   assign swap      = ~x_ff[0] & ~rd_data[0] & ($signed(x_ff) > $signed(rd_data));

   always_comb begin
      wr_en   = 1'b0;
      wr_addr = fill_ff[IDX_W-1:0];
      wr_data = req_data.element_value;
      if (cmd.load) begin
         wr_en = ~fill_full;
      end else if (cmd.cmp) begin
         wr_en   = swap;
         wr_addr = j_ff;
         wr_data = x_ff;
      end else if (cmd.wr_i) begin
         wr_en   = 1'b1;
         wr_addr = i_ff;
         wr_data = x_ff;
      end
   end

   always_comb begin
      case (cmd.rd_sel)
         RD_I:    rd_addr = i_ff;
         RD_I1:   rd_addr = i_ff + IDX_W'(1);
         RD_J1:   rd_addr = j_ff + IDX_W'(1);
         RD_K:    rd_addr = k_ff;
         default: rd_addr = i_ff;
      endcase
   end

   eors_ram #(
      .WIDTH (DATA_W),
      .DEPTH (ROW_LEN)
   ) u_row_store (
      .clock   (clock),
      .wr_en   (wr_en),
      .wr_addr (wr_addr),
      .wr_data (wr_data),
      .rd_en   (cmd.rd_en),
      .rd_addr (rd_addr),
      .rd_data (rd_data)
   );

   always_ff @(posedge clock) begin
      if (reset) begin
         fill_ff      <= '0;
         out_valid_ff <= 1'b0;
      end else begin
         if (close) begin
            fill_ff <= '0;
         end else if (cmd.load && !fill_full) begin
            fill_ff <= fill_ff + CNT_W'(1);
         end
         if (cmd.out_load) begin
            out_valid_ff <= 1'b1;
         end else if (!rsp_stall) begin
            out_valid_ff <= 1'b0;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (close) begin
         len_ff <= len_next;
         i_ff   <= '0;
         k_ff   <= '0;
      end
      if (cmd.inc_i) begin
         i_ff <= i_ff + IDX_W'(1);
      end
      if (cmd.set_j) begin
         j_ff <= i_ff + IDX_W'(1);
      end else if (cmd.cmp) begin
         j_ff <= j_ff + IDX_W'(1);
      end
      if (cmd.cap_x) begin
         x_ff <= rd_data;
      end else if (cmd.cmp && swap) begin
         x_ff <= rd_data;
      end
      if (cmd.out_load) begin
         out_ff.sorted_value <= rd_data;
         out_ff.row_done     <= status.k_last;
         k_ff                <= k_ff + IDX_W'(1);
      end
   end

   assign status.next_len_one = (len_next == CNT_W'(1));
   assign status.j_last       = ({1'b0, j_ff} == CNT_W'(len_ff - CNT_W'(1)));
   assign status.i_last       = ({1'b0, i_ff} == CNT_W'(len_ff - CNT_W'(2)));
   assign status.k_last       = ({1'b0, k_ff} == CNT_W'(len_ff - CNT_W'(1)));
   assign status.out_free     = ~out_valid_ff | ~rsp_stall;

   assign rsp_valid = out_valid_ff;
   assign rsp_data  = out_ff;

endmodule

// ===== src/even_only_row_sort_top.sv =====
// ----------------------------------------------------------------------------
// even_only_row_sort_top
// row loader with in-place exchange sort of even values and row emission
// ----------------------------------------------------------------------------
// Each input beat stores one element in a 64-entry row store with one write
// port and one read port, at one beat per cycle while the input is not
// stalled; elements past ROW_LEN are dropped. The beat with the row end
// mark closes the row of length n, and the input then stalls while the row
// is sorted and emitted. The sort runs one pass per position i, held in a
// register, against every later position, writing the kept value back to
// position i at its end. Emission reads each result from the row store,
// loads it into the output register and waits while an output stall holds
// that register. The input reopens as soon as the last result sits in the
// output register, so a new row can load while that beat waits.
module even_only_row_sort_top (
   input  logic              clock,
   input  logic              reset,
   input  logic              req_valid,
   output logic              req_stall,
   input  eors_pkg::req_type req_data,
   output logic              rsp_valid,
   input  logic              rsp_stall,
   output eors_pkg::rsp_type rsp_data
);
   import eors_pkg::*;

   dp_cmd_type    cmd;
   dp_status_type status;

   eors_ctrl u_ctrl (
      .clock       (clock),
      .reset       (reset),
      .req_valid   (req_valid),
      .req_row_end (req_data.row_end),
      .req_stall   (req_stall),
      .status      (status),
      .cmd         (cmd)
   );

   eors_dpath u_dpath (
      .clock     (clock),
      .reset     (reset),
      .req_data  (req_data),
      .rsp_stall (rsp_stall),
      .rsp_valid (rsp_valid),
      .rsp_data  (rsp_data),
      .cmd       (cmd),
      .status    (status)
   );

endmodule
